>>> rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

  // Field widths of the command and result transactions.
  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READOUT  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_COUNT    = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] status;
  } plan_t;

endpackage

`default_nettype wire

>>> rtl/positional_list_engine_core.sv
`default_nettype none

// Ordered list of up to CAPACITY signed words, held packed in one memory.
// A command transaction is taken on a rising edge with start high and busy
// low. Results leave on the out_ ports, each for one cycle with out_valid
// high; out_last marks the final result of a command. The receiver cannot
// stall, so results are never held back.
// Count reports and every rejected command give their result in the cycle after
// acceptance and leave busy low, so such commands may follow every cycle.
// An insert keeps busy high while it moves the elements at and after its index
// one slot up; a delete likewise moves the elements after the deleted one a
// slot down. The result follows the last busy cycle. The single write port of
// the list memory moves one element per cycle.
// A readout keeps busy high until it has read its last element and streams one
// element per cycle, each through the memory read register and then the output
// register; an empty readout answers like a count report.
// Reset empties the list at once; the memory itself is not cleared, since
// only entries below the count are ever read.
module positional_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [ple_pkg::CMD_W-1:0]    in_command,
  input  wire logic signed [ple_pkg::VAL_W-1:0]    in_value,
  input  wire logic        [ple_pkg::POS_W-1:0]    in_position,
  output logic                                     out_valid,
  output logic             [ple_pkg::STAT_W-1:0]   out_status,
  output logic signed      [ple_pkg::VAL_W-1:0]    out_element,
  output logic             [ple_pkg::CNT_W-1:0]    out_count,
  output logic                                     out_last
);

  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]        state_r,    state_nxt;
  logic [CW-1:0]     count_r,    count_nxt;
  logic              dir_up_r,   dir_up_nxt;
  logic [AW-1:0]     idx_r,      idx_nxt;
  logic [VAL_W-1:0]  val_r,      val_nxt;
  logic [AW-1:0]     ptr_r,      ptr_nxt;
  logic              rd_act_r,   rd_act_nxt;
  logic              pend_r,     pend_nxt;
  logic [AW-1:0]     wa_r,       wa_nxt;
  logic              plast_r,    plast_nxt;
  logic              ovalid_r,   ovalid_nxt;
  logic [STAT_W-1:0] ostatus_r,  ostatus_nxt;
  logic [VAL_W-1:0]  oelem_r,    oelem_nxt;
  logic [CNT_W-1:0]  ocount_r,   ocount_nxt;
  logic              olast_r,    olast_nxt;

  logic              accept;
  plan_t             dec_plan;
  logic [AW-1:0]     dec_idx;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     stop_ptr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  ple_decode #(
    .CAPACITY (CAPACITY)
  ) u_decode (
    .command  (in_command),
    .position (in_position),
    .count    (count_r),
    .plan     (dec_plan),
    .idx      (dec_idx)
  );

  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = state_r != S_IDLE;
  assign accept   = start && !busy;
  assign cnt_m1   = count_r - CW'(1);
  // Inserts shift downwards to the insert index; deletes upwards to the tail.
  assign stop_ptr = dir_up_r ? idx_r : cnt_m1[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dir_up_nxt  = dir_up_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    ptr_nxt     = ptr_r;
    rd_act_nxt  = rd_act_r;
    pend_nxt    = pend_r;
    wa_nxt      = wa_r;
    plast_nxt   = plast_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ST_OK;
    oelem_nxt   = '0;
    ocount_nxt  = ocount_r;
    olast_nxt   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wa_r;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (dec_plan.op)
            OP_INSERT: begin
              state_nxt  = S_MOVE;
              dir_up_nxt = 1'b1;
              idx_nxt    = dec_idx;
              val_nxt    = in_value;
              pend_nxt   = 1'b0;
              rd_act_nxt = count_r > CW'(dec_idx);
              ptr_nxt    = cnt_m1[AW-1:0];
            end
            OP_DELETE: begin
              state_nxt  = S_MOVE;
              dir_up_nxt = 1'b0;
              idx_nxt    = dec_idx;
              pend_nxt   = 1'b0;
              rd_act_nxt = (CW'(dec_idx) + CW'(1)) < count_r;
              ptr_nxt    = dec_idx + AW'(1);
            end
            OP_READ: begin
              state_nxt  = S_READ;
              pend_nxt   = 1'b0;
              rd_act_nxt = 1'b1;
              ptr_nxt    = '0;
            end
            default: begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = dec_plan.status;
              ocount_nxt  = CNT_W'(count_r);
              olast_nxt   = 1'b1;
            end
          endcase
        end
      end

      S_MOVE: begin
        // Read one entry ahead and write it back one slot over in the next cycle.
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (rd_act_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r;
          pend_nxt  = 1'b1;
          wa_nxt    = dir_up_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
          ptr_nxt   = dir_up_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
          if (ptr_r == stop_ptr) begin
            rd_act_nxt = 1'b0;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (!rd_act_r && !pend_r) begin
          if (dir_up_r) begin
            ram_we    = 1'b1;
            ram_waddr = idx_r;
            ram_wdata = val_r;
            count_nxt = count_r + CW'(1);
          end else begin
            count_nxt = cnt_m1;
          end
          state_nxt   = S_IDLE;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          ocount_nxt  = CNT_W'(count_nxt);
          olast_nxt   = 1'b1;
        end
      end

      S_READ: begin
        if (rd_act_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r;
          pend_nxt  = 1'b1;
          plast_nxt = ptr_r == cnt_m1[AW-1:0];
          ptr_nxt   = ptr_r + AW'(1);
          if (ptr_r == cnt_m1[AW-1:0]) begin
            rd_act_nxt = 1'b0;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          oelem_nxt   = ram_rdata;
          ocount_nxt  = CNT_W'(count_r);
          olast_nxt   = plast_r;
          if (plast_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rd_act_r <= 1'b0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_act_r <= rd_act_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_up_r  <= dir_up_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    ptr_r     <= ptr_nxt;
    wa_r      <= wa_nxt;
    plast_r   <= plast_nxt;
    ostatus_r <= ostatus_nxt;
    oelem_r   <= oelem_nxt;
    ocount_r  <= ocount_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid   = ovalid_r;
  assign out_status  = ostatus_r;
  assign out_element = $signed(oelem_r);
  assign out_count   = ocount_r;
  assign out_last    = olast_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> CW'(ram_waddr) <= count_r)
    else $error("memory write beyond the end of the list");

  a_long_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dec_plan.op != OP_NONE) |=> busy)
    else $error("multi-cycle command did not raise busy");

  a_count_changes_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> (out_valid && out_last))
    else $error("count changed without a final result");

  a_readout_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("readout stream has a gap");
`endif

endmodule

`default_nettype wire

>>> rtl/ple_ram.sv
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ple_decode.sv
`default_nettype none

module ple_decode #(
  parameter int CAPACITY = 32
) (
  input  wire logic [ple_pkg::CMD_W-1:0]          command,
  input  wire logic [ple_pkg::POS_W-1:0]          position,
  input  wire logic [$clog2(CAPACITY+1)-1:0]      count,
  output ple_pkg::plan_t                          plan,
  output logic      [$clog2(CAPACITY)-1:0]        idx
);

  import ple_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CMPW-1:0] cnt_e;
  logic [CMPW-1:0] pos_e;
  logic [CMPW-1:0] pos_m1;
  logic [CW-1:0]   cnt_m1;
  logic            full;
  logic            empty;
  logic            pos_zero;

  assign cnt_e    = CMPW'(count);
  assign pos_e    = CMPW'(position);
  assign pos_m1   = pos_e - CMPW'(1);
  assign cnt_m1   = count - CW'(1);
  assign full     = cnt_e >= CMPW'(CAPACITY);
  assign empty    = count == '0;
  assign pos_zero = position == '0;

  always_comb begin
    plan.op     = OP_NONE;
    plan.status = ST_OK;
    idx         = '0;
    case (command)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.op = OP_INSERT;
          idx     = (command == CMD_INS_HEAD) ? '0 : count[AW-1:0];
        end
      end
      CMD_INS_POS: begin
        // The position check takes precedence over the full check.
        if (pos_zero || (pos_e > cnt_e + CMPW'(1))) begin
          plan.status = ST_BAD_POS;
        end else if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.op = OP_INSERT;
          idx     = pos_m1[AW-1:0];
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.op = OP_DELETE;
          idx     = (command == CMD_DEL_HEAD) ? '0 : cnt_m1[AW-1:0];
        end
      end
      CMD_DEL_POS: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else if (pos_zero || (pos_e > cnt_e)) begin
          plan.status = ST_BAD_POS;
        end else begin
          plan.op = OP_DELETE;
          idx     = pos_m1[AW-1:0];
        end
      end
      CMD_READOUT: begin
        if (!empty) begin
          plan.op = OP_READ;
        end
      end
      default: begin
        plan.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire
